// ===== src/single_precision_hypot_macros.svh =====
// Assertion macros for the hypot block.
`ifndef SINGLE_PRECISION_HYPOT_MACROS_SVH
`define SINGLE_PRECISION_HYPOT_MACROS_SVH
`ifndef SYNTHESIS
`define HYP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HYP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HYP_ASSERT_IMP(label, clk, rst, ante, cons)
`define HYP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/sph_pkg.sv =====
package sph_pkg;
  localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
  localparam logic [30:0] INF_MAG    = 31'h7F80_0000;
  localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
  localparam logic [31:0] CANON_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
  localparam int          ROOT_BITS  = 55;
  localparam int          FRAC_W     = 112;

  typedef struct packed {
    logic [31:0] res;
    logic        inv;
    logic        ovf;
    logic        unf;
    logic        inx;
  } result_t;

  // Item carried through the root pipeline.
  typedef struct packed {
    logic        special;
    result_t     spec;
    logic [10:0] ef;
    logic [FRAC_W-1:0] rad;
    logic [FRAC_W-1:0] rem;
    logic [ROOT_BITS+1:0] q;
  } root_item_t;
endpackage

// ===== src/single_precision_hypot.sv =====
// Single-precision hypotenuse, sqrt(x*x + y*y), with IEEE flags.
// Input stream s_axis: tdata holds x_bits [31:0] and y_bits [63:32].
// Output stream m_axis: tdata holds result_bits [31:0]; tuser holds the flags
// invalid, overflow, underflow, inexact from bit 0 up.
// Throughput is one word per clock while m_axis does not stall. The stages are
// the input register, one to square, one to normalize the squares, one to add,
// one to round the sum to double, 55 for the digit-per-stage square root, one
// to round the root to double, and the output register, which rounds to single.
// The pipeline advances as one: when m_axis stalls with a word held in the
// output register, every stage holds, and s_axis_tready drops. No word is
// lost or repeated. Reset clears all valid bits; data registers are not reset.
// Infinities, NaNs and zero operands are resolved in the first stage and ride
// through the pipeline beside the numeric path.
// Squares are exact in 48 bits; their sum is rounded to double precision
// (nearest even) before the root, matching double arithmetic.
`include "single_precision_hypot_macros.svh"
module single_precision_hypot (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // x_bits, y_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result_bits
  output logic [3:0]  m_axis_tuser    // invalid, overflow, underflow, inexact
);
  import sph_pkg::*;

  localparam int NST = ROOT_BITS;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 0: decode, special cases, unpack
  logic        v0;
  logic        sp0;
  result_t     spr0;
  logic [23:0] mx0, my0;
  logic signed [9:0] ex0, ey0;

  logic [31:0] xb, yb;
  logic [30:0] ax, ay;
  logic        xsnan, ysnan;
  result_t     spc;
  logic        spf;
  always_comb begin
    xb = s_axis_tdata[31:0];
    yb = s_axis_tdata[63:32];
    ax = xb[30:0];
    ay = yb[30:0];
    xsnan = (ax > INF_MAG) && !ax[22];
    ysnan = (ay > INF_MAG) && !ay[22];
    spc = '0;
    spf = 1'b1;
    if (ax >= INF_MAG || ay >= INF_MAG) begin
      if (ax == INF_MAG || ay == INF_MAG) begin
        spc.res = INF_BITS;
        if (xsnan) begin
          spc.res = {1'b0, ax}; spc.inv = 1'b1;
        end else if (ysnan) begin
          spc.res = {1'b0, ay}; spc.inv = 1'b1;
        end
      end else if (xsnan) begin
        spc.res = xb | QUIET_BIT; spc.inv = 1'b1;
      end else if (ysnan) begin
        spc.res = yb | QUIET_BIT; spc.inv = 1'b1;
      end else begin
        spc.res = CANON_QNAN;
      end
    end else if (ax == '0) begin
      spc.res = {1'b0, ay};
    end else if (ay == '0) begin
      spc.res = {1'b0, ax};
    end else begin
      spf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sp0  <= spf;
      spr0 <= spc;
      mx0  <= {(ax[30:23] != 8'd0), ax[22:0]};
      my0  <= {(ay[30:23] != 8'd0), ay[22:0]};
      ex0  <= (ax[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, ax[30:23]});
      ey0  <= (ay[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, ay[30:23]});
    end
  end

  // stage 1: squares (value = m^2 * 2^(2e-300))
  logic        v1, sp1;
  result_t     spr1;
  logic [47:0] sqx1, sqy1;
  logic signed [10:0] e2x1, e2y1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sp1  <= sp0;
      spr1 <= spr0;
      sqx1 <= mx0 * mx0;
      sqy1 <= my0 * my0;
      e2x1 <= 11'(ex0) <<< 1;
      e2y1 <= 11'(ey0) <<< 1;
    end
  end

  // stage 2: normalize each square so its top bit is set
  logic        v2, sp2;
  result_t     spr2;
  logic [47:0] nx2, ny2;
  logic signed [11:0] ex2, ey2;   // exponent of the square's lsb
  logic [5:0]  lzx, lzy;
  always_comb begin
    lzx = 6'd0;
    lzy = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (sqx1[i]) lzx = 6'(47 - i);
      if (sqy1[i]) lzy = 6'(47 - i);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sp2  <= sp1;
      spr2 <= spr1;
      nx2  <= sqx1 << lzx;
      ny2  <= sqy1 << lzy;
      ex2  <= 12'(e2x1) - 12'sd300 - $signed({6'd0, lzx});
      ey2  <= 12'(e2y1) - 12'sd300 - $signed({6'd0, lzy});
    end
  end

  // stage 3: align the smaller square and add; keep six fraction bits
  // below the larger square's lsb, everything further down folds into sticky
  logic        v3, sp3;
  result_t     spr3;
  logic [54:0] sum3;
  logic        stk3;
  logic signed [11:0] eb3;
  logic [47:0] big, sml;
  logic signed [11:0] eb, esm;
  logic [11:0] dsh;
  logic [53:0] sml_w, sml_sh;
  logic        stk;
  always_comb begin
    if (ex2 >= ey2) begin
      big = nx2; eb = ex2; sml = ny2; esm = ey2;
    end else begin
      big = ny2; eb = ey2; sml = nx2; esm = ex2;
    end
    dsh   = $unsigned(eb - esm);
    sml_w = {sml, 6'd0};
    if (dsh >= 12'd54) begin
      sml_sh = '0;
      stk    = (sml != '0);
    end else begin
      sml_sh = sml_w >> dsh[5:0];
      stk    = ((sml_w << (6'd54 - dsh[5:0])) != '0);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sp3  <= sp2;
      spr3 <= spr2;
      sum3 <= {1'b0, big, 6'd0} + {1'b0, sml_sh};
      stk3 <= stk;
      eb3  <= eb;
    end
  end

  // stage 4: round the sum to a 53-bit double significand, nearest even
  logic        v4, sp4;
  result_t     spr4;
  logic [52:0] m4;
  logic signed [12:0] e4;   // exponent of m4 lsb
  logic [52:0] mk;
  logic        rbit, sbit;
  logic [53:0] mr;
  logic signed [12:0] el;
  always_comb begin
    if (sum3[54]) begin
      mk   = sum3[54:2];
      rbit = sum3[1];
      sbit = sum3[0] | stk3;
      el   = 13'(eb3) - 13'sd4;
    end else begin
      mk   = sum3[53:1];
      rbit = sum3[0];
      sbit = stk3;
      el   = 13'(eb3) - 13'sd5;
    end
    mr = {1'b0, mk} + 54'(rbit && (sbit || mk[0]));
    if (mr[53]) begin
      mr = mr >> 1;
      el = el + 13'sd1;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sp4  <= sp3;
      spr4 <= spr3;
      m4   <= mr[52:0];
      e4   <= el;
    end
  end

  // radicand set up for the root (even exponent)
  root_item_t ri;
  logic signed [12:0] eh;
  logic [53:0] mm;
  always_comb begin
    ri = '0;
    ri.special = sp4;
    ri.spec    = spr4;
    if (e4[0]) begin
      mm = {m4, 1'b0};
      eh = e4 - 13'sd1;
    end else begin
      mm = {1'b0, m4};
      eh = e4;
    end
    ri.rad = {mm, 58'd0};
    ri.ef  = 11'(eh >>> 1) + 11'd1200;
  end

  logic       rv [0:NST];
  root_item_t rit[0:NST];
  assign rv[0]  = v4;
  assign rit[0] = ri;
  for (genvar gs = 0; gs < NST; gs++) begin : g_root
    sph_root_stage u_st (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(rv[gs]), .in_item(rit[gs]),
      .out_valid(rv[gs+1]), .out_item(rit[gs+1])
    );
  end

  // round root to 53 bits, then to single
  root_item_t fin;
  logic       v5;
  logic [54:0] q55;
  logic [53:0] r53;
  logic signed [12:0] rexp;
  logic [1:0] qlo;
  assign fin = rit[NST];
  assign q55 = fin.q[54:0];
  assign qlo = q55[1:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= rv[NST];
    end
  end
  logic sp5;
  result_t spr5;
  logic [52:0] m5;
  logic signed [12:0] e5;
  always_comb begin
    r53 = {1'b0, q55[54:2]};
    if (qlo[1] && (qlo[0] || fin.rem != '0 || r53[0])) r53 = r53 + 54'd1;
    rexp = $signed({2'b00, fin.ef}) - 13'sd1200;
    if (r53[53]) begin
      r53  = r53 >> 1;
      rexp = rexp + 13'sd1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sp5  <= fin.special;
      spr5 <= fin.spec;
      m5   <= r53[52:0];
      // value = m5 * 2^(e5) with m5 in [2^52,2^53): root lsb weight
      e5   <= rexp - 13'sd26;
    end
  end

  // final: double -> single (RNE), flags
  result_t outr;
  logic signed [12:0] fe;
  logic [52:0] md;
  logic [7:0]  shr;
  logic [52:0] keep;
  logic [24:0] mf;
  logic        g, st;
  always_comb begin
    md = m5;
    fe = e5 + 13'sd52 + 13'sd127;  // biased single exponent of leading bit
    outr = '0;
    if (fe >= 13'sd1) begin
      shr = 8'd29;
    end else if (fe > -13'sd30) begin
      shr = 8'(13'sd30 - fe);
    end else begin
      shr = 8'd60;
    end
    keep = (shr >= 8'd53) ? 53'd0 : (md >> shr);
    g    = (shr >= 8'd54) ? 1'b0 : md[shr-1];
    st   = ((md << (8'd54 - shr)) != '0) && (shr <= 8'd54) || (shr > 8'd54);
    mf   = {1'b0, keep[23:0]};
    if (g && (st || keep[0])) mf = mf + 25'd1;
    if (fe >= 13'sd1) begin
      // overflow is decided on the double root, before rounding to single
      if (fe > 13'sd254 || (fe == 13'sd254 && md[52:29] == '1 && md[28:0] != '0)) begin
        outr.res = INF_BITS; outr.ovf = 1'b1; outr.inx = 1'b1;
      end else if (mf[24]) begin
        outr.res = {1'b0, 8'(fe + 13'sd1), 23'd0};
      end else begin
        outr.res = {1'b0, 8'(fe), mf[22:0]};
      end
    end else begin
      outr.res = {1'b0, 8'(mf[23]), mf[22:0]};
      if (!mf[23]) begin
        outr.unf = 1'b1; outr.inx = 1'b1;
      end
    end
    if (sp5) outr = spr5;
  end
  result_t ro;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ro <= outr;
    end
  end
  assign m_axis_tdata = ro.res;
  assign m_axis_tuser = {ro.inx, ro.unf, ro.ovf, ro.inv};

  `HYP_ASSERT_IMP(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `HYP_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `HYP_ASSERT_IMP(a_inx_pair, clk, rst, m_axis_tvalid,
    !m_axis_tuser[3] || m_axis_tuser[1] || m_axis_tuser[2])
endmodule

// ===== src/sph_root_stage.sv =====
// One digit of the restoring square root per stage: bring down a radicand pair,
// subtract the trial value, shift in the next root bit.
module sph_root_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  sph_pkg::root_item_t in_item,
  output logic               out_valid,
  output sph_pkg::root_item_t out_item
);
  import sph_pkg::*;

  logic [FRAC_W-1:0] r_sh;
  logic [FRAC_W-1:0] t;
  logic [FRAC_W-1:0] r_sub;
  logic              take;
  root_item_t        item_next;

  always_comb begin
    item_next = in_item;
    r_sh  = {in_item.rem[FRAC_W-3:0], in_item.rad[FRAC_W-1 -: 2]};
    t     = {{(FRAC_W-ROOT_BITS-4){1'b0}}, in_item.q, 2'b01};
    r_sub = r_sh - t;
    take  = (r_sh >= t);
    item_next.rad = {in_item.rad[FRAC_W-3:0], 2'b00};
    item_next.rem = take ? r_sub : r_sh;
    item_next.q   = {in_item.q[ROOT_BITS:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import sph_pkg::*;

  localparam int  LATENCY     = 62;
  localparam real FLOAT_LIMIT = 3.40282346638528859812e+38;
  localparam logic [31:0] MAX_NORM = 32'h7F7F_FFFF;
  localparam logic [31:0] MIN_SUB  = 32'h0000_0001;
  localparam logic [31:0] SNAN_POS = 32'h7F80_0001;
  localparam logic [31:0] SNAN_NEG = 32'hFFA0_0005;
  localparam logic [31:0] QNAN_NEG = 32'hFFC0_1234;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  result_t hyp_expected[$];
  int      mismatches = 0;
  bit      hold_request = 1'b0;

  single_precision_hypot i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #4 clk = ~clk;

  // Widen a positive nonzero finite single to a double value.
  function automatic real single_to_real(input logic [30:0] mag);
    logic [7:0]  e;
    logic [23:0] m;
    int          sh;
    e  = mag[30:23];
    m  = {1'b0, mag[22:0]};
    sh = 0;
    if (e != 0) begin
      return $bitstoreal({1'b0, 11'(e + 896), mag[22:0], 29'b0});
    end
    while (!m[23]) begin
      m  = m << 1;
      sh = sh + 1;
    end
    return $bitstoreal({1'b0, 11'(897 - sh), m[22:0], 29'b0});
  endfunction

  function automatic logic [63:0] shift_rne(input logic [63:0] m, input int s);
    logic [63:0] q, rem, half;
    if (s >= 64) return '0;
    q    = m >> s;
    rem  = m & ((64'd1 << s) - 1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return q;
  endfunction

  // Round a positive double (at most the single maximum) to single, nearest even.
  function automatic logic [31:0] real_to_single(input real v);
    logic [63:0] b, m;
    int          fe;
    b  = $realtobits(v);
    m  = {11'b0, 1'b1, b[51:0]};
    fe = int'(b[62:52]) - 896;
    if (fe >= 1) begin
      m = shift_rne(m, 29);
      if (m[24]) begin
        fe = fe + 1;
        m  = m >> 1;
      end
      return {1'b0, 8'(fe), m[22:0]};
    end
    return 32'(shift_rne(m, 30 - fe));
  endfunction

  function automatic result_t hypot_of(input logic [31:0] xb, input logic [31:0] yb);
    result_t     r;
    logic [31:0] ax, ay;
    bit          x_snan, y_snan;
    real         dx, dy, root;
    r  = '0;
    ax = xb & ~SIGN_MASK;
    ay = yb & ~SIGN_MASK;
    x_snan = ax > INF_BITS && (ax & QUIET_BIT) == 0;
    y_snan = ay > INF_BITS && (ay & QUIET_BIT) == 0;
    if (ax >= INF_BITS || ay >= INF_BITS) begin
      if (ax == INF_BITS || ay == INF_BITS) begin
        r.res = INF_BITS;
        if (x_snan) begin
          r.res = ax;
          r.inv = 1'b1;
        end else if (y_snan) begin
          r.res = ay;
          r.inv = 1'b1;
        end
      end else if (x_snan) begin
        r.res = xb | QUIET_BIT;
        r.inv = 1'b1;
      end else if (y_snan) begin
        r.res = yb | QUIET_BIT;
        r.inv = 1'b1;
      end else begin
        r.res = CANON_QNAN;
      end
    end else if (ax == 0) begin
      r.res = ay;
    end else if (ay == 0) begin
      r.res = ax;
    end else begin
      dx   = single_to_real(ax[30:0]);
      dy   = single_to_real(ay[30:0]);
      root = $sqrt(dx * dx + dy * dy);
      if (root > FLOAT_LIMIT) begin
        r.res = INF_BITS;
        r.ovf = 1'b1;
        r.inx = 1'b1;
      end else begin
        r.res = real_to_single(root);
        if (r.res[31:23] == 0) begin
          r.unf = 1'b1;
          r.inx = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Hold valid high until the word is taken; valid stays high for the next word.
  task automatic send_pair(input logic [31:0] xb, input logic [31:0] yb);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {yb, xb};
    do @(posedge clk); while (!s_axis_tready);
    hyp_expected.push_back(hypot_of(xb, yb));
  endtask

  task automatic idle_sender(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 11))
      0: v[30:23] = 8'hFF;                                    // inf or NaN
      1: v[30:0]  = $urandom_range(0, 3) == 0 ? '0 : v[30:0] & 31'h0000_00FF;
      2: v[30:23] = 8'h00;                                    // subnormal
      3: v[30:23] = 8'(8'hF0 + $urandom_range(0, 14));        // near overflow
      4: v[30:23] = 8'($urandom_range(0, 12));                // near underflow
      5: v[30:0]  = $urandom_range(0, 1) ? INF_MAG : {8'hFF, 1'b0, 22'($urandom)};
      default: v[30:23] = 8'($urandom_range(100, 154));       // everyday range
    endcase
    return v;
  endfunction

  task automatic send_random_pairs(input int count);
    int          burst;
    logic [31:0] xb, yb;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && count > 0) begin
        xb = random_operand();
        case ($urandom_range(0, 5))
          0: yb = xb ^ ($urandom_range(0, 1) << 31);          // equal magnitudes
          1: yb = {$urandom_range(0, 1) == 1, xb[30:23], 23'($urandom)};
          default: yb = random_operand();
        endcase
        send_pair(xb, yb);
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
    end
    idle_sender(0);
  endtask

  task automatic test_special_cases();
    send_pair(32'h0000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'hC0A0_0000);
    send_pair(32'h3F80_0000, 32'h0000_0000);
    send_pair(INF_BITS, SNAN_NEG);
    send_pair(SNAN_POS, 32'hFF80_0000);
    send_pair(32'hFF80_0000, QNAN_NEG);
    send_pair(INF_BITS, INF_BITS);
    send_pair(SNAN_NEG, SNAN_POS);
    send_pair(QNAN_NEG, SNAN_POS);
    send_pair(QNAN_NEG, CANON_QNAN);
    send_pair(32'h3F80_0000, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    idle_sender(3);
    send_pair(32'h4040_0000, 32'h4080_0000);                   // 3, 4
    send_pair(MAX_NORM, MAX_NORM);
    send_pair(MAX_NORM, 32'h0000_0001);
    send_pair(32'h7F3F_FFFF, 32'h7F3F_FFFF);
    send_pair(MIN_SUB, MIN_SUB);
    send_pair(32'h8000_0003, MIN_SUB);
    send_pair(32'h007F_FFFF, 32'h807F_FFFF);
    send_pair(32'h0080_0000, MIN_SUB);
    send_pair(32'h3F80_0000, 32'h3380_0000);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    idle_sender(0);
    wait (hyp_expected.size() == 0);
  endtask

  task automatic test_random_traffic();
    send_random_pairs(900);
  endtask

  task automatic test_output_hold();
    @(posedge clk);
    hold_request = 1'b1;
    send_random_pairs(150);
    wait (hyp_expected.size() == 0);
  endtask

  task automatic test_after_drain();
    send_random_pairs(100);
  endtask

  // Receiver: stall on its own pattern, or hold off for a long stretch on request.
  initial begin
    int period, duty, phase;
    period = 4;
    duty   = 3;
    phase  = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_request = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) begin
        period = $urandom_range(1, 9);
        duty   = $urandom_range(0, 2) == 0 ? period : $urandom_range(1, period);
      end
      phase = (phase + 1) % period;
      m_axis_tready <= phase < duty;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (hyp_expected.size() == 0) begin
        $display("%0t: result with none expected: %h/%b", $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = hyp_expected.pop_front();
        if (m_axis_tdata !== want.res) begin
          $display("%0t: result_bits expected %h actual %h", $time, want.res, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.inv) begin
          $display("%0t: invalid expected %b actual %b", $time, want.inv, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, want.ovf, m_axis_tuser[1]);
          mismatches++;
        end
        if (m_axis_tuser[2] !== want.unf) begin
          $display("%0t: underflow expected %b actual %b", $time, want.unf, m_axis_tuser[2]);
          mismatches++;
        end
        if (m_axis_tuser[3] !== want.inx) begin
          $display("%0t: inexact expected %b actual %b", $time, want.inx, m_axis_tuser[3]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_random_traffic();
    test_output_hold();
    test_after_drain();
    wait (hyp_expected.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && hyp_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/sph_pkg.sv
src/sph_root_stage.sv
src/single_precision_hypot.sv
tb/sv/tb.sv
